// ----- rtl/bfdh_pkg.sv -----
`default_nettype none

package bfdh_pkg;

   // filter geometry
   localparam int MAX_BITS    = 65536;
   localparam int MAX_PROBES  = 16;
   localparam int SIZE_W      = $clog2(MAX_BITS) + 1;
   localparam int IDX_W       = $clog2(MAX_BITS);
   localparam int PROBE_W     = $clog2(MAX_PROBES) + 1;
   localparam int PROBE_SEL_W = $clog2(MAX_PROBES);
   localparam int TINY_LIMIT  = 2;

   // bit store organized as wide rows
   localparam int ROW_W      = 64;
   localparam int ROWS       = MAX_BITS / ROW_W;
   localparam int ROW_ADDR_W = $clog2(ROWS);
   localparam int BIT_SEL_W  = $clog2(ROW_W);

   // hashes and counters
   localparam int HASH_W  = 64;
   localparam int COUNT_W = 32;
   localparam int HCNT_W  = 5;
   localparam int CUBE_W  = 12;

   // modulo unit: bits retired per cycle
   localparam int DIV_STEP   = 4;
   localparam int DIV_ITERS  = HASH_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

   // config port
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_COUNT  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_HASH_COUNT = CSR_INDEX_W'(1);

   // opcodes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // stream widths
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 56;

   // status of the modulo unit
   typedef struct packed {
      logic busy;
      logic done;
   } bfdh_mod_status_type;

   // access to the bit store
   typedef struct packed {
      logic                  rd_en;
      logic                  wr_en;
      logic [ROW_ADDR_W-1:0] addr;
      logic [ROW_W-1:0]      wdata;
   } bfdh_mem_req_type;

   // cubic term of the probe sequence, probe index at most 15
   function automatic logic [CUBE_W-1:0] probe_cube(input logic [PROBE_SEL_W-1:0] i);
      logic [CUBE_W-1:0] w;
      w = CUBE_W'(i);
      return CUBE_W'(w * w * w);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bfdh_mod.sv -----
`default_nettype none

module bfdh_mod (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [bfdh_pkg::HASH_W-1:0]   dividend,
   input  wire logic [bfdh_pkg::SIZE_W-1:0]   divisor,
   output bfdh_pkg::bfdh_mod_status_type      status,
   output logic [bfdh_pkg::SIZE_W-1:0]        remainder
);

   logic [bfdh_pkg::HASH_W-1:0]    dvd_ff, dvd_in;
   logic [bfdh_pkg::SIZE_W-1:0]    dvs_ff;
   logic [bfdh_pkg::SIZE_W-1:0]    rem_ff, rem_in;
   logic [bfdh_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;

   // restoring remainder steps, several dividend bits per cycle
   always_comb begin
      logic [bfdh_pkg::SIZE_W:0]     t;
      logic [bfdh_pkg::SIZE_W-1:0]   r;
      logic [bfdh_pkg::HASH_W-1:0]   d;
      r = rem_ff;
      d = dvd_ff;
      for (int k = 0; k < bfdh_pkg::DIV_STEP; k++) begin
         t = {r, d[bfdh_pkg::HASH_W-1]};
         d = {d[bfdh_pkg::HASH_W-2:0], 1'b0};
         if (t >= {1'b0, dvs_ff}) begin
            t = t - {1'b0, dvs_ff};
         end
         r = t[bfdh_pkg::SIZE_W-1:0];
      end
      rem_in = r;
      dvd_in = d;
   end

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            done_ff <= 1'b0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == bfdh_pkg::DIV_CNT_W'(bfdh_pkg::DIV_ITERS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               done_ff <= 1'b0;
            end
         end else begin
            done_ff <= 1'b0;
         end
      end
   end

   // operand and partial remainder registers
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/bfdh_store.sv -----
`default_nettype none

module bfdh_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          clear_start,
   input  wire bfdh_pkg::bfdh_mem_req_type    req,
   output logic [bfdh_pkg::ROW_W-1:0]         rd_data,
   output logic                               busy
);

   logic [bfdh_pkg::ROW_W-1:0]      mem [bfdh_pkg::ROWS];
   logic [bfdh_pkg::ROW_W-1:0]      rd_data_ff;
   logic [bfdh_pkg::ROW_ADDR_W-1:0] clr_addr_ff;
   logic                            clr_busy_ff;

   // clearing sweep, one row per cycle, runs after reset and after every clear_start
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_start) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == bfdh_pkg::ROW_ADDR_W'(bfdh_pkg::ROWS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // single write port shared by sweep and row updates
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (req.wr_en) begin
         mem[req.addr] <= req.wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

`default_nettype wire

// ----- rtl/bloom_filter_double_hash.sv -----
// per key: a tiny filter or zero probes goes straight to the result, else each probe (until
//   a lookup misses) runs the one shared 64-bit modulo unit, retiring 4 bits a cycle, then a row read and update
// throughput: one key at a time; a new key is taken only after the last result is loaded
// reset: synchronous; a clearing pass over all 1024 rows of the bit store follows reset
//   and every bit_count write, req_tready stays low during it
`default_nettype none

module bloom_filter_double_hash (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // req_tdata: opcode[0], hash_first[64:1], hash_second[128:65], zero fill
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [bfdh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: present[0], set_bits[17:1], inserted[49:18], zero fill
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [bfdh_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                               csr_wr_en,
   input  wire logic [bfdh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bfdh_pkg::SIZE_W-1:0]        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_MOD,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type                        state_ff;
   logic                             insert_ff;
   logic [bfdh_pkg::HASH_W-1:0]      stride_ff;
   logic [bfdh_pkg::HASH_W-1:0]      acc_ff;
   logic [bfdh_pkg::SIZE_W-1:0]      size_ff;
   logic [bfdh_pkg::PROBE_W-1:0]     probes_ff;
   logic [bfdh_pkg::PROBE_W-1:0]     probe_ff;
   logic [bfdh_pkg::IDX_W-1:0]       idx_ff;
   logic                             present_ff;
   logic                             tiny_ff;
   logic [bfdh_pkg::SIZE_W-1:0]      ones_ff;
   logic [bfdh_pkg::COUNT_W-1:0]     elem_ff;
   logic [bfdh_pkg::SIZE_W-1:0]      bit_count_ff;
   logic [bfdh_pkg::HCNT_W-1:0]      hash_count_ff;
   logic                             rsp_valid_ff;
   logic                             rsp_present_ff;
   logic [bfdh_pkg::SIZE_W-1:0]      rsp_set_bits_ff;
   logic [bfdh_pkg::COUNT_W-1:0]     rsp_inserted_ff;

   logic                             req_opcode;
   logic [bfdh_pkg::HASH_W-1:0]      req_hash_first;
   logic [bfdh_pkg::HASH_W-1:0]      req_hash_second;
   logic                             accept;
   logic [bfdh_pkg::SIZE_W-1:0]      size_eff;
   logic [bfdh_pkg::PROBE_W-1:0]     probes_eff;
   logic                             tiny;
   logic                             clear_start;
   logic                             store_busy;
   logic [bfdh_pkg::ROW_W-1:0]       row_data;
   logic                             hit;
   logic [bfdh_pkg::PROBE_W-1:0]     probe_in;
   logic [bfdh_pkg::HASH_W-1:0]      mod_dividend;
   logic [bfdh_pkg::SIZE_W-1:0]      mod_rem;
   bfdh_pkg::bfdh_mod_status_type    mod_stat;
   bfdh_pkg::bfdh_mem_req_type       mem_req;

   // unpack request beat
   assign req_opcode      = req_tdata[0];
   assign req_hash_first  = req_tdata[bfdh_pkg::HASH_W:1];
   assign req_hash_second = req_tdata[2*bfdh_pkg::HASH_W:bfdh_pkg::HASH_W+1];

   assign req_tready = (state_ff == ST_IDLE) && !store_busy;
   assign accept     = req_tvalid && req_tready;

   // effective size and probe count
   assign size_eff   = (bit_count_ff > bfdh_pkg::SIZE_W'(bfdh_pkg::MAX_BITS))
                       ? bfdh_pkg::SIZE_W'(bfdh_pkg::MAX_BITS) : bit_count_ff;
   assign probes_eff = (hash_count_ff > bfdh_pkg::HCNT_W'(bfdh_pkg::MAX_PROBES))
                       ? bfdh_pkg::PROBE_W'(bfdh_pkg::MAX_PROBES)
                       : bfdh_pkg::PROBE_W'(hash_count_ff);
   assign tiny       = size_eff <= bfdh_pkg::SIZE_W'(bfdh_pkg::TINY_LIMIT);

   assign clear_start = csr_wr_en && (csr_index == bfdh_pkg::REG_BIT_COUNT);

   // probe address: base + i*stride accumulated, plus the cube term
   assign mod_dividend = acc_ff
                       + bfdh_pkg::HASH_W'(bfdh_pkg::probe_cube(
                            probe_ff[bfdh_pkg::PROBE_SEL_W-1:0]));

   bfdh_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == ST_CALC),
      .dividend  (mod_dividend),
      .divisor   (size_ff),
      .status    (mod_stat),
      .remainder (mod_rem)
   );

   // row read and read-modify-write of the probed bit
   assign hit            = row_data[idx_ff[bfdh_pkg::BIT_SEL_W-1:0]];
   assign mem_req.rd_en  = (state_ff == ST_READ);
   assign mem_req.wr_en  = (state_ff == ST_CHECK) && insert_ff && !hit;
   assign mem_req.addr   = idx_ff[bfdh_pkg::IDX_W-1:bfdh_pkg::BIT_SEL_W];
   assign mem_req.wdata  = row_data
                         | (bfdh_pkg::ROW_W'(1) << idx_ff[bfdh_pkg::BIT_SEL_W-1:0]);

   bfdh_store u_store (
      .clock       (clock),
      .reset       (reset),
      .clear_start (clear_start),
      .req         (mem_req),
      .rd_data     (row_data),
      .busy        (store_busy)
   );

   assign probe_in = probe_ff + 1'b1;

   // sequencer, counters and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ones_ff       <= '0;
         elem_ff       <= '0;
         bit_count_ff  <= bfdh_pkg::SIZE_W'(bfdh_pkg::MAX_BITS);
         hash_count_ff <= bfdh_pkg::HCNT_W'(4);
         rsp_valid_ff  <= 1'b0;
      end else begin
         // result beat loads in finish and leaves on the handshake
         if ((state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  insert_ff  <= (req_opcode == bfdh_pkg::OP_INSERT);
                  acc_ff     <= req_hash_first;
                  stride_ff  <= req_hash_second;
                  size_ff    <= size_eff;
                  probes_ff  <= probes_eff;
                  probe_ff   <= '0;
                  present_ff <= 1'b1;
                  tiny_ff    <= tiny;
                  if ((req_opcode == bfdh_pkg::OP_INSERT) && (elem_ff != '1)) begin
                     elem_ff <= elem_ff + 1'b1;
                  end
                  if (tiny || (probes_eff == '0)) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_CALC;
                  end
               end
            end
            ST_CALC: begin
               state_ff <= ST_MOD;
            end
            ST_MOD: begin
               if (mod_stat.done) begin
                  idx_ff   <= mod_rem[bfdh_pkg::IDX_W-1:0];
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               probe_ff <= probe_in;
               acc_ff   <= acc_ff + stride_ff;
               if (insert_ff && !hit) begin
                  ones_ff <= ones_ff + 1'b1;
               end
               if (!insert_ff && !hit) begin
                  present_ff <= 1'b0;
                  state_ff   <= ST_FINISH;
               end else if (probe_in == probes_ff) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_CALC;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_present_ff  <= insert_ff ? 1'b0 : present_ff;
                  rsp_set_bits_ff <= tiny_ff ? bfdh_pkg::SIZE_W'(bfdh_pkg::TINY_LIMIT)
                                             : ones_ff;
                  rsp_inserted_ff <= elem_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // config writes, to be made only while idle; the block itself does not enforce this
         if (clear_start) begin
            bit_count_ff <= csr_wdata;
            ones_ff      <= '0;
            elem_ff      <= '0;
         end else if (csr_wr_en && (csr_index == bfdh_pkg::REG_HASH_COUNT)) begin
            hash_count_ff <= csr_wdata[bfdh_pkg::HCNT_W-1:0];
         end
      end
   end

   // pack response beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      (bfdh_pkg::RSP_DATA_W - 1 - bfdh_pkg::SIZE_W - bfdh_pkg::COUNT_W)'(0),
      rsp_inserted_ff, rsp_set_bits_ff, rsp_present_ff
   };

   // remainder from the shared unit always addresses inside the filter
   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD && mod_stat.done) |-> (mod_rem < size_ff))
      else $error("probe remainder not below filter size");

   // the sequencer only waits on the modulo unit while it is working
   a_mod_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> (mod_stat.busy || mod_stat.done))
      else $error("waiting on idle modulo unit");

   // set bit count never exceeds the store
   a_ones_bound: assert property (@(posedge clock) disable iff (reset)
      ones_ff <= bfdh_pkg::SIZE_W'(bfdh_pkg::MAX_BITS))
      else $error("set bit count overflow");

   // element count only drops on a resize
   a_elem_mono: assert property (@(posedge clock) disable iff (reset)
      !clear_start |=> (elem_ff >= $past(elem_ff)))
      else $error("element count decreased");

   // one key at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("accepted a key while busy");

endmodule

`default_nettype wire
